// File: design/fdvf_pkg.sv
// Package: shared constants, types and tap weights of the deinterlace vertical filter.
`timescale 1ns / 1ps
package fdvf_pkg;

   // Column geometry
   localparam int MAX_COLUMN_ROWS = 2048;
   localparam int ROW_W           = $clog2(MAX_COLUMN_ROWS);
   localparam int WIN_ROWS        = 11;
   localparam int CENTRE          = 5;
   localparam int TAPS            = 6;
   localparam int TAP_W           = $clog2(TAPS + 1);

   // Arithmetic widths
   localparam int WGT_W  = 9;   // signed tap weight
   localparam int WA_W   = 17;  // weight * alpha
   localparam int SA_W   = 18;  // alpha sum
   localparam int SW_W   = 10;  // weight sum
   localparam int SC_W   = 26;  // colour sum
   localparam int REM_W  = 27;  // divider remainder
   localparam int QB     = 9;   // quotient bits kept, top one means saturate

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE,
      CH_ALPHA
   } chan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_ACC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT,
      ST_FLUSH,
      ST_TEST
   } state_type;

   typedef struct packed {
      logic             shift_in;
      logic             shift_flush;
      logic             clear_vld;
      logic             acc_clear;
      logic             tap_en;
      logic [TAP_W-1:0] tap_idx;
      logic             div_start;
      chan_type         div_sel;
      logic             load_out;
      logic             kept;
      logic [ROW_W-1:0] row;
      logic             done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic centre_vld;
      logic div_done;
      logic out_free;
   } dp_status_type;

   // Weights 9,-50,225,225,-50,9 (exact over 368)
   function automatic logic signed [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] k);
      logic signed [WGT_W-1:0] w;
      case (k)
         3'd0:    w = 9'sd9;
         3'd1:    w = -9'sd50;
         3'd2:    w = 9'sd225;
         3'd3:    w = 9'sd225;
         3'd4:    w = -9'sd50;
         3'd5:    w = 9'sd9;
         default: w = 9'sd0;
      endcase
      return w;
   endfunction

endpackage

// File: design/fdvf_div.sv
// Serial restoring divider: rounded, clamped 8-bit ratio of two signed sums.
`timescale 1ns / 1ps
module fdvf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [fdvf_pkg::SC_W-1:0]   num,
   input  logic signed [fdvf_pkg::SA_W-1:0]   den,
   output logic                               done,
   output logic [7:0]                         quo
);
   import fdvf_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] trial_ff, trial_in;
   logic [QB-1:0]    q_ff, q_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;
   logic             bit_ok;

   assign bit_ok = rem_ff >= trial_ff;

   // Load 2*num+den over 2*den<<8, then one quotient bit per cycle
   always_comb begin
      rem_in   = rem_ff;
      trial_in = trial_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      if (start) begin
         zero_in  = (num <= 0) || (den <= 0);
         rem_in   = REM_W'({num[SC_W-2:0], 1'b0}) + REM_W'(den[SA_W-2:0]);
         trial_in = REM_W'({den[SA_W-2:0], 1'b0, 8'd0});
         q_in     = '0;
         cnt_in   = 4'd8;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (bit_ok) begin
            rem_in = rem_ff - trial_ff;
         end
         q_in     = {q_ff[QB-2:0], bit_ok};
         trial_in = trial_ff >> 1;
         cnt_in   = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      trial_ff <= trial_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      zero_ff  <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = zero_ff ? 8'd0 : (q_ff[QB-1] ? 8'hFF : q_ff[7:0]);

endmodule

// File: design/fdvf_datapath.sv
// Datapath: row window, tap accumulation, divider and output register.
`timescale 1ns / 1ps
module fdvf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  fdvf_pkg::ctrl_cmd_type  cmd,
   output fdvf_pkg::dp_status_type status,
   input  logic [31:0]             pixel,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,
   output logic                    rsp_tlast
);
   import fdvf_pkg::*;

   logic [31:0]           win_ff [WIN_ROWS];
   logic [31:0]           win_in [WIN_ROWS];
   logic [WIN_ROWS-1:0]   vld_ff, vld_in;

   logic signed [WA_W-1:0]  wa1_ff, wa1_in;
   logic signed [WGT_W-1:0] w1_ff, w1_in;
   logic [7:0]              r1_ff, g1_ff, b1_ff, r1_in, g1_in, b1_in;
   logic                    t1_ff, t1_in;

   logic signed [SA_W-1:0] sa_ff, sa_in;
   logic signed [SW_W-1:0] sw_ff, sw_in;
   logic signed [SC_W-1:0] sr_ff, sg_ff, sb_ff, sr_in, sg_in, sb_in;

   logic [7:0] res_r_ff, res_g_ff, res_b_ff, res_a_ff;
   logic [7:0] res_r_in, res_g_in, res_b_in, res_a_in;

   logic        ovld_ff, ovld_in;
   logic [47:0] odata_ff, odata_in;
   logic        olast_ff, olast_in;

   logic [31:0]              tap_px;
   logic                     tap_vld;
   logic signed [WGT_W-1:0]  tap_w;
   logic signed [2*WGT_W-1:0] wa_full;
   logic signed [SC_W-1:0]   pr, pg, pb;
   logic signed [SC_W-1:0]   div_num;
   logic signed [SA_W-1:0]   div_den;
   logic                     div_done;
   logic [7:0]               div_quo;
   logic [31:0]              centre_px;
   logic [31:0]              out_px;

   // Window shift: new rows at slot 0, flush pushes empty slots
   always_comb begin
      win_in = win_ff;
      vld_in = vld_ff;
      if (cmd.clear_vld) begin
         vld_in = '0;
      end else if (cmd.shift_in || cmd.shift_flush) begin
         for (int i = WIN_ROWS - 1; i > 0; i--) begin
            win_in[i] = win_ff[i-1];
         end
         win_in[0] = pixel;
         vld_in    = {vld_ff[WIN_ROWS-2:0], cmd.shift_in};
      end
   end

   // Tap select: tap k sits at slot 10-2k
   always_comb begin
      case (cmd.tap_idx)
         3'd0:    begin tap_px = win_ff[10]; tap_vld = vld_ff[10]; end
         3'd1:    begin tap_px = win_ff[8];  tap_vld = vld_ff[8];  end
         3'd2:    begin tap_px = win_ff[6];  tap_vld = vld_ff[6];  end
         3'd3:    begin tap_px = win_ff[4];  tap_vld = vld_ff[4];  end
         3'd4:    begin tap_px = win_ff[2];  tap_vld = vld_ff[2];  end
         3'd5:    begin tap_px = win_ff[0];  tap_vld = vld_ff[0];  end
         default: begin tap_px = win_ff[0];  tap_vld = 1'b0;       end
      endcase
   end

   assign tap_w   = tap_weight(cmd.tap_idx);
   assign wa_full = tap_w * $signed({1'b0, tap_px[31:24]});

   // Stage one: weighted alpha of the tap
   always_comb begin
      wa1_in = wa1_ff;
      w1_in  = w1_ff;
      r1_in  = r1_ff;
      g1_in  = g1_ff;
      b1_in  = b1_ff;
      t1_in  = cmd.tap_en;
      if (cmd.tap_en) begin
         wa1_in = tap_vld ? wa_full[WA_W-1:0] : '0;
         w1_in  = tap_vld ? tap_w : '0;
         r1_in  = tap_px[7:0];
         g1_in  = tap_px[15:8];
         b1_in  = tap_px[23:16];
      end
   end

   assign pr = wa1_ff * $signed({1'b0, r1_ff});
   assign pg = wa1_ff * $signed({1'b0, g1_ff});
   assign pb = wa1_ff * $signed({1'b0, b1_ff});

   // Stage two: accumulate sums
   always_comb begin
      sa_in = sa_ff;
      sw_in = sw_ff;
      sr_in = sr_ff;
      sg_in = sg_ff;
      sb_in = sb_ff;
      if (cmd.acc_clear) begin
         sa_in = '0;
         sw_in = '0;
         sr_in = '0;
         sg_in = '0;
         sb_in = '0;
      end else if (t1_ff) begin
         sa_in = sa_ff + SA_W'(wa1_ff);
         sw_in = sw_ff + SW_W'(w1_ff);
         sr_in = sr_ff + pr;
         sg_in = sg_ff + pg;
         sb_in = sb_ff + pb;
      end
   end

   // Divider operands per channel
   always_comb begin
      case (cmd.div_sel)
         CH_RED:   begin div_num = sr_ff; div_den = sa_ff; end
         CH_GREEN: begin div_num = sg_ff; div_den = sa_ff; end
         CH_BLUE:  begin div_num = sb_ff; div_den = sa_ff; end
         CH_ALPHA: begin div_num = SC_W'(sa_ff); div_den = SA_W'(sw_ff); end
         default:  begin div_num = '0; div_den = '0; end
      endcase
   end

   fdvf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Capture quotients
   always_comb begin
      res_r_in = res_r_ff;
      res_g_in = res_g_ff;
      res_b_in = res_b_ff;
      res_a_in = res_a_ff;
      if (div_done) begin
         case (cmd.div_sel)
            CH_RED:   res_r_in = div_quo;
            CH_GREEN: res_g_in = div_quo;
            CH_BLUE:  res_b_in = div_quo;
            CH_ALPHA: res_a_in = div_quo;
            default:  res_a_in = res_a_ff;
         endcase
      end
   end

   assign centre_px = win_ff[CENTRE];
   assign out_px    = cmd.kept ? centre_px : {res_a_ff, res_b_ff, res_g_ff, res_r_ff};

   // Output register
   always_comb begin
      ovld_in  = ovld_ff;
      odata_in = odata_ff;
      olast_in = olast_ff;
      if (ovld_ff && rsp_tready) begin
         ovld_in = 1'b0;
      end
      if (cmd.load_out) begin
         ovld_in  = 1'b1;
         odata_in = {5'd0, cmd.row, out_px};
         olast_in = cmd.done;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      wa1_ff   <= wa1_in;
      w1_ff    <= w1_in;
      r1_ff    <= r1_in;
      g1_ff    <= g1_in;
      b1_ff    <= b1_in;
      sa_ff    <= sa_in;
      sw_ff    <= sw_in;
      sr_ff    <= sr_in;
      sg_ff    <= sg_in;
      sb_ff    <= sb_in;
      res_r_ff <= res_r_in;
      res_g_ff <= res_g_in;
      res_b_ff <= res_b_in;
      res_a_ff <= res_a_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      if (reset) begin
         vld_ff  <= '0;
         t1_ff   <= 1'b0;
         ovld_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         t1_ff   <= t1_in;
         ovld_ff <= ovld_in;
      end
   end

   assign status.centre_vld = vld_ff[CENTRE];
   assign status.div_done   = div_done;
   assign status.out_free   = !ovld_ff || rsp_tready;

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;

endmodule

// File: design/fdvf_ctrl.sv
// Controller: sequences row intake, tap accumulation, division and flush.
`timescale 1ns / 1ps
module fdvf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tlast,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  fdvf_pkg::dp_status_type status,
   output fdvf_pkg::ctrl_cmd_type  cmd
);
   import fdvf_pkg::*;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] rows_ff, rows_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_ff, last_in;
   logic             flushing_ff, flushing_in;
   logic [2:0]       flush_cnt_ff, flush_cnt_in;
   logic [TAP_W-1:0] tap_cnt_ff, tap_cnt_in;
   chan_type         ch_ff, ch_in;
   logic             rebuild_ff;
   logic             last_now;
   logic             kept;

   // Row is rebuilt when its evenness matches the register
   assign kept     = ((!row_ff[0]) != rebuild_ff);
   assign last_now = req_tlast || (rows_ff == ROW_W'(MAX_COLUMN_ROWS - 1));

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      flushing_in  = flushing_ff;
      flush_cnt_in = flush_cnt_ff;
      tap_cnt_in   = tap_cnt_ff;
      ch_in        = ch_ff;
      req_tready   = 1'b0;
      cmd             = '0;
      cmd.tap_idx     = tap_cnt_ff;
      cmd.div_sel     = ch_ff;
      cmd.kept        = kept;
      cmd.row         = row_ff;
      cmd.done        = flushing_ff && (flush_cnt_ff == 3'd5);
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.shift_in = 1'b1;
               row_in       = rows_ff - ROW_W'(CENTRE);
               last_in      = last_now;
               flushing_in  = 1'b0;
               flush_cnt_in = 3'd0;
               rows_in      = last_now ? '0 : rows_ff + ROW_W'(1);
               if (rows_ff >= ROW_W'(CENTRE)) begin
                  state_in = ST_EMIT;
               end else if (last_now) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_EMIT: begin
            if (kept) begin
               state_in = ST_OUT;
            end else begin
               cmd.acc_clear = 1'b1;
               tap_cnt_in    = '0;
               state_in      = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.tap_en = (tap_cnt_ff < TAP_W'(TAPS));
            tap_cnt_in = tap_cnt_ff + TAP_W'(1);
            if (tap_cnt_ff == TAP_W'(TAPS)) begin
               ch_in    = CH_RED;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (ch_ff == CH_ALPHA) begin
                  state_in = ST_OUT;
               end else begin
                  ch_in    = chan_type'(ch_ff + 2'd1);
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (flushing_ff) begin
                  if (flush_cnt_ff == 3'd5) begin
                     cmd.clear_vld = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else if (last_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            cmd.shift_flush = 1'b1;
            flushing_in     = 1'b1;
            flush_cnt_in    = flush_cnt_ff + 3'd1;
            row_in          = row_ff + ROW_W'(1);
            state_in        = ST_TEST;
         end
         ST_TEST: begin
            state_in = status.centre_vld ? ST_EMIT : ST_FLUSH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      last_ff    <= last_in;
      tap_cnt_ff <= tap_cnt_in;
      ch_ff      <= ch_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         flushing_ff  <= 1'b0;
         flush_cnt_ff <= 3'd0;
         rebuild_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         flushing_ff  <= flushing_in;
         flush_cnt_ff <= flush_cnt_in;
         if (csr_wr_en) begin
            rebuild_ff <= csr_wr_data;
         end
      end
   end

endmodule

// File: design/field_deinterlace_vertical_filter.sv
// A row leaves five rows after it arrives; a kept row goes from select to the output load,
// a rebuilt row through select, tap accumulation, four divisions and the output load.
// A new beat is taken only in idle, once the previous row is done and loaded for output;
// rebuilt rows are paced by the single serial divider shared by the four channels.
// Reset (synchronous): empty window, row count zero, no result held, even rows rebuilt.
`timescale 1ns / 1ps
module field_deinterlace_vertical_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // in_red, in_green, in_blue, in_alpha
   input  logic        req_tlast,  // end_of_column
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_red, out_green, out_blue, out_alpha, out_row, pad
   output logic        rsp_tlast,  // column_done
   input  logic        csr_wr_en,
   input  logic        csr_wr_data // rebuild_even_rows
);
   import fdvf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fdvf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   fdvf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pixel      (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: verif/tb.sv
// Testbench for the deinterlace vertical filter: directed and random columns checked by a predictor.
`timescale 1ns / 1ps
module tb;
   import fdvf_pkg::*;

   typedef struct {
      logic [7:0]  red, green, blue, alpha;
      logic [10:0] row;
      logic        done;
   } out_pix_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [31:0] req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en, csr_wr_data;

   field_deinterlace_vertical_filter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Predictor state
   logic [31:0] win_px [WIN_ROWS];
   int          rows_in;
   logic        even_rebuilt;
   out_pix_type pending_pix [$];
   int          fails = 0;
   int          hold_cnt;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [7:0] round_div(longint num, longint den);
      longint q;
      if (num <= 0 || den <= 0) return 8'd0;
      q = (2 * num + den) / (2 * den);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic out_pix_type rebuild_row(int y, int newest, bit last_one);
      out_pix_type o;
      longint sr, sg, sb, sa, sw, wa;
      int sy;
      logic [31:0] p;
      longint wts [6];
      wts = '{9, -50, 225, 225, -50, 9};
      sr = 0; sg = 0; sb = 0; sa = 0; sw = 0;
      p = win_px[y % WIN_ROWS];
      if ((y % 2 == 0) == even_rebuilt) begin
         for (int k = 0; k < 6; k++) begin
            sy = y - 5 + 2 * k;
            if (sy < 0 || sy > newest) continue;
            p  = win_px[sy % WIN_ROWS];
            wa = wts[k] * longint'(p[31:24]);
            sr += wa * p[7:0];
            sg += wa * p[15:8];
            sb += wa * p[23:16];
            sa += wa;
            sw += wts[k];
         end
         if (sa > 0) begin
            o.red = round_div(sr, sa); o.green = round_div(sg, sa);
            o.blue = round_div(sb, sa); o.alpha = round_div(sa, sw);
         end else begin
            o.red = 0; o.green = 0; o.blue = 0; o.alpha = 0;
         end
      end else begin
         o.red = p[7:0]; o.green = p[15:8]; o.blue = p[23:16]; o.alpha = p[31:24];
      end
      o.row  = y[10:0];
      o.done = last_one;
      return o;
   endfunction

   // Queue the rows a pixel beat releases
   task automatic predict_beat(logic [31:0] px, logic last);
      int n;
      bit fin;
      n = rows_in;
      win_px[n % WIN_ROWS] = px;
      fin = last || (n + 1 >= MAX_COLUMN_ROWS);
      if (n >= 5) pending_pix.push_back(rebuild_row(n - 5, n, 0));
      if (fin) begin
         for (int y = (n >= 5 ? n - 4 : 0); y <= n; y++)
            pending_pix.push_back(rebuild_row(y, n, y == n));
         rows_in = 0;
      end else begin
         rows_in = n + 1;
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Valid stays high after a beat until the next gap or drain lowers it
   task automatic send_pixel(logic [31:0] px, logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= px;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beat(px, last);
   endtask

   task automatic drain_and_write(logic val);
      int guard;
      guard = 0;
      req_tvalid <= 0;
      while (pending_pix.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 0;
      even_rebuilt = val;
   endtask

   task automatic send_column(int len, bit full_range);
      logic [31:0] px;
      for (int i = 0; i < len; i++) begin
         px = $urandom;
         if (!full_range && $urandom_range(0, 3) == 0) px[31:24] = 8'hFF;
         send_pixel(px, i == len - 1);
      end
   endtask

   // Result monitor with random stall
   always @(posedge clock) begin
      out_pix_type e;
      if (reset) begin
         rsp_tready <= 0;
         hold_cnt   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pix.size() == 0) begin
               $error("unexpected beat row %0d", rsp_tdata[42:32]);
               fails++;
            end else begin
               e = pending_pix.pop_front();
               if (rsp_tdata[7:0] !== e.red) begin
                  $error("out_red exp %0d got %0d", e.red, rsp_tdata[7:0]); fails++;
               end
               if (rsp_tdata[15:8] !== e.green) begin
                  $error("out_green exp %0d got %0d", e.green, rsp_tdata[15:8]); fails++;
               end
               if (rsp_tdata[23:16] !== e.blue) begin
                  $error("out_blue exp %0d got %0d", e.blue, rsp_tdata[23:16]); fails++;
               end
               if (rsp_tdata[31:24] !== e.alpha) begin
                  $error("out_alpha exp %0d got %0d", e.alpha, rsp_tdata[31:24]); fails++;
               end
               if (rsp_tdata[42:32] !== e.row) begin
                  $error("out_row exp %0d got %0d", e.row, rsp_tdata[42:32]); fails++;
               end
               if (rsp_tlast !== e.done) begin
                  $error("column_done exp %0d got %0d", e.done, rsp_tlast); fails++;
               end
            end
         end
         if (hold_cnt > 0) begin
            rsp_tready <= 0;
            hold_cnt   <= hold_cnt - 1;
         end else begin
            rsp_tready <= 1;
            hold_cnt   <= gap_len();
         end
      end
   end

   // Directed pixels: {pixel, last}
   typedef struct { logic [31:0] px; logic last; } dir_row_type;
   dir_row_type dir_rows [$];

   initial begin
      int guard;
      rows_in = 0; even_rebuilt = 1;
      foreach (win_px[i]) win_px[i] = 0;
      reset = 1; req_tvalid = 0; req_tdata = 0; req_tlast = 0;
      csr_wr_en = 0; csr_wr_data = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // One-row column (row 0 rebuilt: no taps, all zero)
      dir_rows.push_back('{32'hFFFF_FFFF, 1});
      // Two-row column, extremes
      dir_rows.push_back('{32'h0000_0000, 0});
      dir_rows.push_back('{32'hFFFF_FFFF, 1});
      // Zero alpha column of eight rows
      for (int i = 0; i < 8; i++) dir_rows.push_back('{32'h00FF_00FF, i == 7});
      // Checkerboard alpha to reach clamping and negative sums
      for (int i = 0; i < 12; i++)
         dir_rows.push_back('{(i % 4 < 2) ? 32'hFFFF_FFFF : 32'h0100_0000, i == 11});
      foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].last);

      // Odd rows rebuilt
      drain_and_write(0);
      send_column(1, 1);
      send_column(7, 0);
      send_column(20, 1);
      drain_and_write(1);
      send_column(13, 0);

      // Random columns of 1 to 16 rows, register rewritten at random between
      for (int c = 0; c < 4; c++) begin
         if ($urandom_range(0, 1)) drain_and_write($urandom_range(0, 1));
         send_column($urandom_range(1, 16), $urandom_range(0, 1));
      end
      drain_and_write(1);
      send_column(9, 1);
      req_tvalid <= 0;

      guard = 0;
      while (pending_pix.size() != 0 && guard < 500000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
      if (fails == 0 && pending_pix.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
